@@ rtl/core/llce_pkg.sv @@
// ----------------------------------------------------------------------------
// llce_pkg
// Shared types and constants of the linked list cursor engine.
// ----------------------------------------------------------------------------
`default_nettype none

package llce_pkg;

   localparam int CAPACITY_DEFAULT = 16;
   localparam int VALUE_W          = 32;
   localparam int ENTRIES_W        = 5;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_FIRST  = 2'd1,
      OP_NEXT   = 2'd2,
      OP_REMOVE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_END        = 2'd1,
      ST_FULL       = 2'd2,
      ST_NO_CURRENT = 2'd3
   } status_type;

   typedef struct packed {
      op_type                     opcode;
      logic signed [VALUE_W-1:0]  value;
   } req_type;

   typedef struct packed {
      status_type                 status;
      logic signed [VALUE_W-1:0]  item;
      logic [ENTRIES_W-1:0]       entries;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/core/llce_slot_store.sv @@
// ----------------------------------------------------------------------------
// llce_slot_store
// Value and link memories of the list slots, one write and one read address
// per cycle, registered read data with write-to-read bypass.
// ----------------------------------------------------------------------------
`default_nettype none

module llce_slot_store #(
   parameter int CAPACITY = llce_pkg::CAPACITY_DEFAULT,
   localparam int AW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   localparam int IDX_W   = $clog2(CAPACITY + 1)
) (
   input  wire logic                              clock,
   input  wire logic [AW-1:0]                     rd_addr,
   input  wire logic [AW-1:0]                     wr_addr,
   input  wire logic                              val_we,
   input  wire logic signed [llce_pkg::VALUE_W-1:0] val_wd,
   input  wire logic                              lnk_we,
   input  wire logic [IDX_W-1:0]                  lnk_wd,
   output logic signed [llce_pkg::VALUE_W-1:0]    rd_value_ff,
   output logic [IDX_W-1:0]                       rd_link_ff
);

   logic signed [llce_pkg::VALUE_W-1:0] val_mem [CAPACITY];
   logic [IDX_W-1:0]                    lnk_mem [CAPACITY];

   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[wr_addr] <= val_wd;
      end
      if (lnk_we) begin
         lnk_mem[wr_addr] <= lnk_wd;
      end
   end

   // forward a write that lands on the address being read in the same cycle
   always_ff @(posedge clock) begin
      if (val_we && (wr_addr == rd_addr)) begin
         rd_value_ff <= val_wd;
      end else begin
         rd_value_ff <= val_mem[rd_addr];
      end
      if (lnk_we && (wr_addr == rd_addr)) begin
         rd_link_ff <= lnk_wd;
      end else begin
         rd_link_ff <= lnk_mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/llce_free_map.sv @@
// ----------------------------------------------------------------------------
// llce_free_map
// One bit per slot marking it free; a priority encoder offers the lowest
// free slot for the next insert.
// ----------------------------------------------------------------------------
`default_nettype none

module llce_free_map #(
   parameter int CAPACITY = llce_pkg::CAPACITY_DEFAULT,
   localparam int AW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   localparam int IDX_W   = $clog2(CAPACITY + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              alloc_en,
   input  wire logic [AW-1:0]     alloc_idx,
   input  wire logic              release_en,
   input  wire logic [AW-1:0]     release_idx,
   output logic [IDX_W-1:0]       free_idx,
   output logic                   free_found
);

   logic [CAPACITY-1:0] free_ff;
   logic [CAPACITY-1:0] free_in;

   always_comb begin
      free_in = free_ff;
      if (alloc_en) begin
         free_in[alloc_idx] = 1'b0;
      end
      if (release_en) begin
         free_in[release_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= '1;
      end else begin
         free_ff <= free_in;
      end
   end

   // lowest set bit wins
   always_comb begin
      free_idx   = IDX_W'(CAPACITY);
      free_found = 1'b0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (free_ff[i]) begin
            free_idx   = IDX_W'(i);
            free_found = 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/llce_list_ctrl.sv @@
// ----------------------------------------------------------------------------
// llce_list_ctrl
// Pointer state of the list (front, cursor, previous, link after cursor,
// count) and the result register. Decodes one request per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module llce_list_ctrl #(
   parameter int CAPACITY = llce_pkg::CAPACITY_DEFAULT,
   localparam int AW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   localparam int IDX_W   = $clog2(CAPACITY + 1)
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire llce_pkg::op_type                    acc_op,
   input  wire logic                                s1_valid,
   input  wire llce_pkg::op_type                    s1_op,
   input  wire logic signed [llce_pkg::VALUE_W-1:0] s1_value,
   input  wire logic signed [llce_pkg::VALUE_W-1:0] rd_value,
   input  wire logic [IDX_W-1:0]                    rd_link,
   input  wire logic [IDX_W-1:0]                    free_idx,
   input  wire logic                                free_found,
   output logic [AW-1:0]                            rd_addr,
   output logic [AW-1:0]                            wr_addr,
   output logic                                     val_we,
   output logic signed [llce_pkg::VALUE_W-1:0]      val_wd,
   output logic                                     lnk_we,
   output logic [IDX_W-1:0]                         lnk_wd,
   output logic                                     alloc_en,
   output logic                                     release_en,
   output logic [AW-1:0]                            release_idx,
   output logic                                     rsp_valid_ff,
   output llce_pkg::rsp_type                        rsp_data_ff
);

   localparam logic [IDX_W-1:0] NIL  = IDX_W'(CAPACITY);
   localparam logic [IDX_W-1:0] FULL = IDX_W'(CAPACITY);

   logic [IDX_W-1:0]  front_ff, front_in;
   logic [IDX_W-1:0]  cursor_ff, cursor_in;
   logic [IDX_W-1:0]  prev_ff, prev_in;
   logic [IDX_W-1:0]  cur_link_ff, cur_link_in;   // entry that follows the cursor
   logic [IDX_W-1:0]  count_ff, count_in;
   logic              allowed_ff, allowed_in;
   logic [IDX_W-1:0]  wr_idx;
   logic [IDX_W-1:0]  rd_idx;
   logic [IDX_W+llce_pkg::ENTRIES_W-1:0] count_wide;
   llce_pkg::rsp_type rsp_in;

   always_comb begin
      front_in    = front_ff;
      cursor_in   = cursor_ff;
      prev_in     = prev_ff;
      cur_link_in = cur_link_ff;
      count_in    = count_ff;
      allowed_in  = allowed_ff;
      wr_idx      = free_idx;
      val_we      = 1'b0;
      val_wd      = s1_value;
      lnk_we      = 1'b0;
      lnk_wd      = front_ff;
      alloc_en    = 1'b0;
      release_en  = 1'b0;
      rsp_in.status = llce_pkg::ST_OK;
      rsp_in.item   = '0;
      if (s1_valid) begin
         case (s1_op)
            llce_pkg::OP_INSERT: begin
               if ((count_ff >= FULL) || !free_found) begin
                  rsp_in.status = llce_pkg::ST_FULL;
               end else begin
                  val_we     = 1'b1;
                  lnk_we     = 1'b1;
                  alloc_en   = 1'b1;
                  front_in   = free_idx;
                  count_in   = count_ff + IDX_W'(1);
                  allowed_in = 1'b0;
                  if (cursor_ff == NIL) begin
                     cur_link_in = free_idx;
                  end
               end
            end
            llce_pkg::OP_FIRST: begin
               if (front_ff == NIL) begin
                  rsp_in.status = llce_pkg::ST_END;
               end else begin
                  prev_in     = NIL;
                  cursor_in   = front_ff;
                  cur_link_in = rd_link;
                  rsp_in.item = rd_value;
                  allowed_in  = 1'b1;
               end
            end
            llce_pkg::OP_NEXT: begin
               if (cur_link_ff == NIL) begin
                  rsp_in.status = llce_pkg::ST_END;
               end else begin
                  prev_in     = cursor_ff;
                  cursor_in   = cur_link_ff;
                  cur_link_in = rd_link;
                  rsp_in.item = rd_value;
                  allowed_in  = 1'b1;
               end
            end
            llce_pkg::OP_REMOVE: begin
               if (!allowed_ff || (cursor_ff == NIL)) begin
                  rsp_in.status = llce_pkg::ST_NO_CURRENT;
               end else begin
                  rsp_in.item = rd_value;
                  // unlink: splice the previous entry (or the front) past the cursor
                  if (prev_ff == NIL) begin
                     front_in = cur_link_ff;
                  end else begin
                     lnk_we = 1'b1;
                     wr_idx = prev_ff;
                     lnk_wd = cur_link_ff;
                  end
                  release_en  = 1'b1;
                  cursor_in   = prev_ff;
                  cur_link_in = cur_link_ff;
                  if (count_ff != '0) begin
                     count_in = count_ff - IDX_W'(1);
                  end
                  allowed_in = 1'b0;
               end
            end
            default: begin
               rsp_in.status = llce_pkg::ST_OK;
            end
         endcase
      end
      count_wide     = {{llce_pkg::ENTRIES_W{1'b0}}, count_in};
      rsp_in.entries = count_wide[llce_pkg::ENTRIES_W-1:0];
   end

   assign wr_addr     = wr_idx[AW-1:0];
   assign release_idx = cursor_ff[AW-1:0];

   // read address for the request being taken now, from the state it will see
   always_comb begin
      case (acc_op)
         llce_pkg::OP_FIRST: rd_idx = front_in;
         llce_pkg::OP_NEXT:  rd_idx = cur_link_in;
         default:            rd_idx = cursor_in;
      endcase
   end

   assign rd_addr = rd_idx[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= NIL;
         cursor_ff    <= NIL;
         prev_ff      <= NIL;
         cur_link_ff  <= NIL;
         count_ff     <= '0;
         allowed_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         cursor_ff    <= cursor_in;
         prev_ff      <= prev_in;
         cur_link_ff  <= cur_link_in;
         count_ff     <= count_in;
         allowed_ff   <= allowed_in;
         rsp_valid_ff <= s1_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_in;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL)
      else $error("entry count above capacity");

   a_allowed_has_cursor: assert property (@(posedge clock) disable iff (reset)
      allowed_ff |-> (cursor_ff != NIL))
      else $error("removal armed with cursor on the head");

   a_head_link: assert property (@(posedge clock) disable iff (reset)
      (cursor_ff == NIL) |-> (cur_link_ff == front_ff))
      else $error("link after head differs from front");

   a_remove_disarms: assert property (@(posedge clock) disable iff (reset)
      (s1_valid && (s1_op == llce_pkg::OP_REMOVE)) |=> !allowed_ff)
      else $error("removal still armed after a remove");
`endif

endmodule

`default_nettype wire

@@ rtl/core/linked_list_cursor_engine.sv @@
// ----------------------------------------------------------------------------
// linked_list_cursor_engine
// Bounded singly linked list with a dummy head and a cursor.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_data and raise start; the request beat is taken at any edge
//   with start high, since busy stays low. Opcodes: insert at front, go to
//   first, go to next, remove current.
//   Each request gives one result beat on rsp_data, marked by rsp_valid for
//   exactly one cycle, with the request register and the result register between.
//   Throughput is one request per cycle: the slot memory read is issued as the
//   request is taken, its data is registered beside the request register, and
//   the result is formed from it while the following request's read is issued.
//   Reset (synchronous) empties the list: all slots free, cursor on the head,
//   count zero. Slot memories hold no reset value and need no clearing.
//   The receiver cannot stall: results are presented once and not held.
// ----------------------------------------------------------------------------
`default_nettype none

module linked_list_cursor_engine #(
   parameter int CAPACITY = llce_pkg::CAPACITY_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire llce_pkg::req_type req_data,
   output logic                   rsp_valid,
   output llce_pkg::rsp_type      rsp_data
);

   localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int IDX_W = $clog2(CAPACITY + 1);

   logic                                s1_valid_ff;
   llce_pkg::op_type                    s1_op_ff;
   logic signed [llce_pkg::VALUE_W-1:0] s1_value_ff;
   logic                                accept;

   logic [AW-1:0]                       rd_addr;
   logic [AW-1:0]                       wr_addr;
   logic                                val_we;
   logic signed [llce_pkg::VALUE_W-1:0] val_wd;
   logic                                lnk_we;
   logic [IDX_W-1:0]                    lnk_wd;
   logic signed [llce_pkg::VALUE_W-1:0] rd_value_ff;
   logic [IDX_W-1:0]                    rd_link_ff;
   logic                                alloc_en;
   logic                                release_en;
   logic [AW-1:0]                       release_idx;
   logic [IDX_W-1:0]                    free_idx;
   logic                                free_found;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff    <= req_data.opcode;
      s1_value_ff <= req_data.value;
   end

   llce_list_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .acc_op       (req_data.opcode),
      .s1_valid     (s1_valid_ff),
      .s1_op        (s1_op_ff),
      .s1_value     (s1_value_ff),
      .rd_value     (rd_value_ff),
      .rd_link      (rd_link_ff),
      .free_idx     (free_idx),
      .free_found   (free_found),
      .rd_addr      (rd_addr),
      .wr_addr      (wr_addr),
      .val_we       (val_we),
      .val_wd       (val_wd),
      .lnk_we       (lnk_we),
      .lnk_wd       (lnk_wd),
      .alloc_en     (alloc_en),
      .release_en   (release_en),
      .release_idx  (release_idx),
      .rsp_valid_ff (rsp_valid),
      .rsp_data_ff  (rsp_data)
   );

   llce_slot_store #(
      .CAPACITY (CAPACITY)
   ) u_store (
      .clock       (clock),
      .rd_addr     (rd_addr),
      .wr_addr     (wr_addr),
      .val_we      (val_we),
      .val_wd      (val_wd),
      .lnk_we      (lnk_we),
      .lnk_wd      (lnk_wd),
      .rd_value_ff (rd_value_ff),
      .rd_link_ff  (rd_link_ff)
   );

   llce_free_map #(
      .CAPACITY (CAPACITY)
   ) u_free (
      .clock       (clock),
      .reset       (reset),
      .alloc_en    (alloc_en),
      .alloc_idx   (wr_addr),
      .release_en  (release_en),
      .release_idx (release_idx),
      .free_idx    (free_idx),
      .free_found  (free_found)
   );

endmodule

`default_nettype wire
